// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rotation matrix RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/aarm_pkg.sv -----
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants, types and helper functions of the rotation matrix unit.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ZW = 34;  // Q2.30 plus guard bits

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

    typedef logic signed [33:0] q30_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  quad;
        q30_t        x;
        q30_t        y;
        q30_t        z;
    } cordic_t;

    function automatic q30_t atan_q30(input int unsigned i);
        q30_t r;
        case (i)
            0:  r = 34'sh3243F6A8;  1: r = 34'sh1DAC6705;
            2:  r = 34'sh0FADBAFC;  3: r = 34'sh07F56EA6;
            4:  r = 34'sh03FEAB76;  5: r = 34'sh01FFD55B;
            6:  r = 34'sh00FFFAAA;  7: r = 34'sh007FFF55;
            8:  r = 34'sh003FFFEA;  9: r = 34'sh001FFFFD;
            10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
            12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF;
            14: r = 34'sh0000FFFF; 15: r = 34'sh00007FFF;
            16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
            18: r = 34'sh00000FFF; 19: r = 34'sh000007FF;
            20: r = 34'sh000003FF; 21: r = 34'sh000001FF;
            22: r = 34'sh000000FF; default: r = 34'sh0000007F;
        endcase
        return r;
    endfunction

    // Q2.30 to Q1.14: round half up, saturate to +-1.0
    function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'sd32768) >>> 16;
        if (r > 36'sd16384)       return ONE_Q14;
        else if (r < -36'sd16384) return -ONE_Q14;
        else                      return r[15:0];
    endfunction

endpackage

// ----- rtl/core/axis_angle_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit
// Axis-angle to 3x3 rotation matrix, pipelined chain of step cells.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: one request per beat. s_tdata holds angle_deg, axis_x, axis_y,
//  axis_z from the low bit up (24+16+16+16 bits). m_axis: one result per
//  request, m_tdata holds m00..m22 (16 bits each, low bits first),
//  m_tuser = zero_axis.
//  Throughput: one request per cycle unless the output stalls. The angle
//  goes through three front stages and CORDIC_STEPS rotation cells; the axis
//  length through a 32-cell square root chain and three 43-cell restoring
//  divider chains in parallel; then two multiply stages, a rounding stage and
//  the output register. The pipe holds 79 register stages; its depth is set
//  by the root and divider chains.
//  The whole pipe advances whenever the output register is empty or being
//  taken (single enable), so a stall on m_tready freezes every stage and
//  s_tready falls with it; no request is dropped.
//  Reset (aresetn low, synchronous) clears the valid flags except the copies in
//  the angle alignment delay; data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module axis_angle_rotation_matrix_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // angle_deg[23:0], axis_x, axis_y, axis_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // m00 m10 m20 m01 m11 m21 m02 m12 m22
    output logic         m_tuser    // zero_axis
);
    import aarm_pkg::*;

    localparam int SQ_STEPS  = 32;   // root of a 64-bit radicand
    localparam int DV_STEPS  = 43;   // quotient bits for (mag << 42) / len
    localparam int FRONT     = 3;    // angle reduction stages
    localparam int NORM_LAT  = SQ_STEPS + DV_STEPS;
    localparam int ANG_LAT   = FRONT + CORDIC_STEPS;
    localparam int ALIGN     = NORM_LAT - ANG_LAT;   // positive for CORDIC_STEPS < 72

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic in_fire;
    assign in_fire = s_tvalid && en;

    logic signed [23:0] ang_in;
    logic signed [15:0] ax_in, ay_in, az_in;
    assign ang_in = s_tdata[23:0];
    assign ax_in  = s_tdata[39:24];
    assign ay_in  = s_tdata[55:40];
    assign az_in  = s_tdata[71:56];

    // ------------------------------------------------------------------
    // Angle front end: reduce mod 92160, then quadrant and radians
    // ------------------------------------------------------------------
    logic        f1_valid_reg;
    logic [16:0] f1_r_reg, f1_r_next;
    logic signed [25:0] ang_ext;
    logic signed [25:0] q_est;
    logic signed [43:0] prod_est;

    always_comb begin
        // floor(a/92160) via reciprocal, then correct
        prod_est  = 44'(ang_in) * 44'sd186414;   // 2^34/92160 = 186413.5, rounded up
        q_est     = 26'(prod_est >>> 34);
        ang_ext   = 26'(ang_in) - 26'(q_est * 26'sd92160);
        if (ang_ext < 0)              ang_ext = ang_ext + 26'sd92160;
        if (ang_ext >= 26'sd92160)    ang_ext = ang_ext - 26'sd92160;
        if (ang_ext >= 26'sd92160)    ang_ext = ang_ext - 26'sd92160;
        f1_r_next = ang_ext[16:0];
    end

    // rem*843314856/11520 = rem*73204 + floor(rem*597/1440); the last term is
    // floor(floor(rem*597/32) * 745655 / 2^25), exact for rem < 23040
    logic [1:0]  quad_w;
    logic [14:0] rem_w;
    logic [23:0] zfine_w;
    logic        f2_valid_reg, f3_valid_reg;
    logic [1:0]  f2_quad_reg, f3_quad_reg;
    logic [31:0] zbase_reg;
    logic [18:0] zhi_reg;
    logic [39:0] zcorr_w;
    logic [33:0] z_reg, z_next;

    always_comb begin
        quad_w = (f1_r_reg >= 17'd69120) ? 2'd3 :
                 (f1_r_reg >= 17'd46080) ? 2'd2 :
                 (f1_r_reg >= 17'd23040) ? 2'd1 : 2'd0;
        rem_w   = 15'(f1_r_reg - 17'(quad_w) * 17'd23040);
        zfine_w = 24'(rem_w) * 24'd597;
        zcorr_w = 40'(zhi_reg) * 40'd745655;
        z_next  = 34'(zbase_reg) + 34'(zcorr_w >> 25);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_fire;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
        if (en) begin
            f1_r_reg    <= f1_r_next;
            f2_quad_reg <= quad_w;
            zbase_reg   <= 32'(rem_w) * 32'd73204;
            zhi_reg     <= zfine_w[23:5];
            f3_quad_reg <= f2_quad_reg;
            z_reg       <= z_next;
        end
    end

    cordic_t cord_in;
    assign cord_in.valid = f3_valid_reg;
    assign cord_in.quad  = f3_quad_reg;
    assign cord_in.x     = GAIN_Q30;
    assign cord_in.y     = '0;
    assign cord_in.z     = q30_t'(z_reg);

    cordic_t cchain [CORDIC_STEPS+1];
    assign cchain[0] = cord_in;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        aarm_cordic_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .din(cchain[i]), .dout(cchain[i+1])
        );
    end

    // Align angle path with normalization path
    cordic_t adly [ALIGN+1];
    assign adly[0] = cchain[CORDIC_STEPS];
    for (genvar i = 0; i < ALIGN; i++) begin : g_adly
        always_ff @(posedge aclk) begin
            if (en) adly[i+1] <= adly[i];
        end
    end

    // ------------------------------------------------------------------
    // Axis path: len2, sqrt chain, divider chains
    // ------------------------------------------------------------------
    localparam int PW = 16*3 + 2;   // axis comps plus class bits
    logic [63:0] len2s;
    assign len2s = {8'd0, 32'(33'(ax_in*ax_in) + 33'(ay_in*ay_in) + 33'(az_in*az_in)), 24'd0};

    logic [1:0] cls_in;  // 1: X, 2: Y, 3: Z unit, 0: general
    assign cls_in = (ax_in == 16'sd4096 && ay_in == 0 && az_in == 0) ? 2'd1 :
                    (ax_in == 0 && ay_in == 16'sd4096 && az_in == 0) ? 2'd2 :
                    (ax_in == 0 && ay_in == 0 && az_in == 16'sd4096) ? 2'd3 : 2'd0;

    // pass bits: valid, zero length, class, axis_z, axis_y, axis_x
    logic [63:0] sq_rem [SQ_STEPS+1];
    logic [63:0] sq_acc [SQ_STEPS+1];
    logic [PW+1:0] sq_pass [SQ_STEPS+1];
    assign sq_rem[0]  = len2s;
    assign sq_acc[0]  = '0;
    assign sq_pass[0] = {in_fire, (len2s == 0), cls_in, az_in, ay_in, ax_in};

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        aarm_sqrt_cell #(.MODE(0), .STEP(SQ_STEPS-1-i), .RW(64), .QW(64), .PW(PW+2)) u_sq (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .rem_in(sq_rem[i]), .acc_in(sq_acc[i]), .pass_in(sq_pass[i]),
            .rem_out(sq_rem[i+1]), .acc_out(sq_acc[i+1]), .pass_out(sq_pass[i+1])
        );
    end

    logic [31:0] len_w;
    assign len_w = sq_acc[SQ_STEPS][31:0];

    // three divider chains: numerator mag << 42, divisor len
    logic [PW+1:0] ctl_d [DV_STEPS+1];
    assign ctl_d[0] = sq_pass[SQ_STEPS];

    logic signed [33:0] unit_v [3];
    for (genvar c = 0; c < 3; c++) begin : g_div
        logic [15:0] comp_w;
        logic [15:0] mag_w;
        logic [75:0] d_rem [DV_STEPS+1];
        logic [63:0] d_acc [DV_STEPS+1];
        logic [32:0] d_pass [DV_STEPS+1];
        assign comp_w     = sq_pass[SQ_STEPS][16*c +: 16];
        assign mag_w      = comp_w[15] ? 16'(-comp_w) : comp_w;
        assign d_rem[0]   = {18'd0, mag_w, 42'd0};
        assign d_acc[0]   = '0;
        assign d_pass[0]  = {comp_w[15], len_w};
        for (genvar i = 0; i < DV_STEPS; i++) begin : g_step
            aarm_sqrt_cell #(.MODE(1), .STEP(DV_STEPS-1-i), .RW(76), .QW(64), .PW(33))
                u_dv (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .rem_in(d_rem[i]), .acc_in(d_acc[i]),
                .pass_in(d_pass[i]),
                .rem_out(d_rem[i+1]), .acc_out(d_acc[i+1]), .pass_out(d_pass[i+1])
            );
        end
        assign unit_v[c] = d_pass[DV_STEPS][32] ? -34'(d_acc[DV_STEPS][33:0])
                                                : 34'(d_acc[DV_STEPS][33:0]);
    end
    for (genvar i = 0; i < DV_STEPS; i++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) ctl_d[i+1][PW+1] <= 1'b0;
            else if (en) ctl_d[i+1][PW+1] <= ctl_d[i][PW+1];
            if (en) ctl_d[i+1][PW:0] <= ctl_d[i][PW:0];
        end
    end

    // ------------------------------------------------------------------
    // Matrix stages
    // ------------------------------------------------------------------
    function automatic logic signed [35:0] mq(input logic signed [35:0] a,
                                              input logic signed [35:0] b);
        logic signed [71:0] p;
        p = 72'(a) * 72'(b) + 72'sd536870912;
        return 36'(p >>> 30);
    endfunction

    cordic_t      av;
    logic signed [35:0] c_w, s_w;
    assign av = adly[ALIGN];
    always_comb begin
        unique case (av.quad)
            2'd0: begin c_w = 36'(av.x);  s_w = 36'(av.y);  end
            2'd1: begin c_w = -36'(av.y); s_w = 36'(av.x);  end
            2'd2: begin c_w = -36'(av.x); s_w = -36'(av.y); end
            default: begin c_w = 36'(av.y); s_w = -36'(av.x); end
        endcase
    end

    // stage A: pair products
    logic               pa_v_reg, pb_v_reg, pc_v_reg;
    logic [1:0]         pa_cls_reg, pb_cls_reg, pc_cls_reg;
    logic               pa_z_reg, pb_z_reg, pc_z_reg;
    logic signed [35:0] pa_c_reg, pa_s_reg, pa_nc_reg;
    logic signed [35:0] pa_xx_reg, pa_yy_reg, pa_zz_reg, pa_xy_reg, pa_yz_reg, pa_zx_reg;
    logic signed [35:0] pa_xs_reg, pa_ys_reg, pa_zs_reg;
    logic signed [35:0] pb_t_reg [6];
    logic signed [35:0] pb_c_reg, pb_xs_reg, pb_ys_reg, pb_zs_reg, pb_s_reg;
    logic signed [15:0] pc_m_reg [9];
    logic signed [15:0] pc_m_next [9];
    logic signed [35:0] ux, uy, uz;
    assign ux = 36'(unit_v[0]);
    assign uy = 36'(unit_v[1]);
    assign uz = 36'(unit_v[2]);

    logic               o_v_reg;
    logic [143:0]       o_d_reg;
    logic               o_z_reg;

    // stage C entries: general path, then unit axis or zero axis overrides
    always_comb begin
        pc_m_next[0] = to_q14(pb_t_reg[0] + pb_c_reg);
        pc_m_next[3] = to_q14(pb_t_reg[3] - pb_zs_reg);
        pc_m_next[6] = to_q14(pb_t_reg[5] + pb_ys_reg);
        pc_m_next[1] = to_q14(pb_t_reg[3] + pb_zs_reg);
        pc_m_next[4] = to_q14(pb_t_reg[1] + pb_c_reg);
        pc_m_next[7] = to_q14(pb_t_reg[4] - pb_xs_reg);
        pc_m_next[2] = to_q14(pb_t_reg[5] - pb_ys_reg);
        pc_m_next[5] = to_q14(pb_t_reg[4] + pb_xs_reg);
        pc_m_next[8] = to_q14(pb_t_reg[2] + pb_c_reg);
        if (pb_cls_reg != 2'd0 || pb_z_reg) begin
            for (int k = 0; k < 9; k++) pc_m_next[k] = '0;
            if (pb_z_reg && pb_cls_reg == 2'd0) begin
                pc_m_next[0] = ONE_Q14; pc_m_next[4] = ONE_Q14; pc_m_next[8] = ONE_Q14;
            end else if (pb_cls_reg == 2'd1) begin
                pc_m_next[0] = ONE_Q14;
                pc_m_next[4] = to_q14(pb_c_reg); pc_m_next[8] = to_q14(pb_c_reg);
                pc_m_next[5] = to_q14(pb_s_reg); pc_m_next[7] = -to_q14(pb_s_reg);
            end else if (pb_cls_reg == 2'd2) begin
                pc_m_next[4] = ONE_Q14;
                pc_m_next[0] = to_q14(pb_c_reg); pc_m_next[8] = to_q14(pb_c_reg);
                pc_m_next[6] = to_q14(pb_s_reg); pc_m_next[2] = -to_q14(pb_s_reg);
            end else begin
                pc_m_next[8] = ONE_Q14;
                pc_m_next[0] = to_q14(pb_c_reg); pc_m_next[4] = to_q14(pb_c_reg);
                pc_m_next[1] = to_q14(pb_s_reg); pc_m_next[3] = -to_q14(pb_s_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_v_reg <= 1'b0; pb_v_reg <= 1'b0; pc_v_reg <= 1'b0; o_v_reg <= 1'b0;
        end else if (en) begin
            pa_v_reg <= ctl_d[DV_STEPS][PW+1];
            pb_v_reg <= pa_v_reg;
            pc_v_reg <= pb_v_reg;
            o_v_reg  <= pc_v_reg;
        end
        if (en) begin
            pa_cls_reg <= ctl_d[DV_STEPS][PW-1:PW-2];
            pa_z_reg   <= ctl_d[DV_STEPS][PW];
            pa_c_reg   <= c_w;  pa_s_reg <= s_w;
            pa_nc_reg  <= 36'(ONE_Q30) - c_w;
            pa_xx_reg  <= mq(ux, ux); pa_yy_reg <= mq(uy, uy); pa_zz_reg <= mq(uz, uz);
            pa_xy_reg  <= mq(ux, uy); pa_yz_reg <= mq(uy, uz); pa_zx_reg <= mq(uz, ux);
            pa_xs_reg  <= mq(ux, s_w); pa_ys_reg <= mq(uy, s_w); pa_zs_reg <= mq(uz, s_w);
            pb_cls_reg <= pa_cls_reg; pb_z_reg <= pa_z_reg;
            pb_c_reg   <= pa_c_reg;   pb_s_reg <= pa_s_reg;
            pb_xs_reg  <= pa_xs_reg;  pb_ys_reg <= pa_ys_reg; pb_zs_reg <= pa_zs_reg;
            pb_t_reg[0] <= mq(pa_xx_reg, pa_nc_reg);
            pb_t_reg[1] <= mq(pa_yy_reg, pa_nc_reg);
            pb_t_reg[2] <= mq(pa_zz_reg, pa_nc_reg);
            pb_t_reg[3] <= mq(pa_xy_reg, pa_nc_reg);
            pb_t_reg[4] <= mq(pa_yz_reg, pa_nc_reg);
            pb_t_reg[5] <= mq(pa_zx_reg, pa_nc_reg);
            pc_cls_reg <= pb_cls_reg; pc_z_reg <= pb_z_reg;
            for (int k = 0; k < 9; k++) pc_m_reg[k] <= pc_m_next[k];
            o_z_reg <= pc_z_reg && (pc_cls_reg == 2'd0);
            for (int k = 0; k < 9; k++) o_d_reg[16*k +: 16] <= pc_m_reg[k];
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_d_reg;
    assign m_tuser  = o_z_reg;

    `ASSERT_CLK(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid,
        "result dropped under stall")
    `ASSERT_CLK(a_ready, aclk, aresetn, s_tready == (!m_tvalid || m_tready),
        "ready not tied to output slot")
    `ASSERT_CLK(a_zero_id, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[15:0] == ONE_Q14,
        "zero axis without identity")
endmodule

// ----- rtl/core/aarm_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One registered CORDIC rotation step, shift and arctangent fixed per cell.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  aarm_pkg::cordic_t din,
    output aarm_pkg::cordic_t dout
);
    import aarm_pkg::*;

    cordic_t cell_reg, cell_next;

    always_comb begin
        cell_next = din;
        if (!din.z[ZW-1]) begin
            cell_next.x = din.x - (din.y >>> STEP);
            cell_next.y = din.y + (din.x >>> STEP);
            cell_next.z = din.z - atan_q30(STEP);
        end else begin
            cell_next.x = din.x + (din.y >>> STEP);
            cell_next.y = din.y - (din.x >>> STEP);
            cell_next.z = din.z + atan_q30(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= din.valid;
        end
        if (en) begin
            cell_reg.quad <= cell_next.quad;
            cell_reg.x    <= cell_next.x;
            cell_reg.y    <= cell_next.y;
            cell_reg.z    <= cell_next.z;
        end
    end

    assign dout = cell_reg;
endmodule

// ----- rtl/core/aarm_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// aarm_sqrt_cell
// Generic registered step cell used for square root and division chains.
// MODE 0: one restoring square root bit; MODE 1: one restoring quotient bit.
// The top pass bit is a flag cleared at reset (request valid or sign); in
// MODE 1 the pass bits below it hold the divisor.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell #(
    parameter int MODE = 0,
    parameter int STEP = 0,
    parameter int RW   = 64,
    parameter int QW   = 64,
    parameter int PW   = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [QW-1:0] acc_in,
    input  logic [PW-1:0] pass_in,
    output logic [RW-1:0] rem_out,
    output logic [QW-1:0] acc_out,
    output logic [PW-1:0] pass_out
);
    localparam int TW = RW + 1;

    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] acc_reg, acc_next;
    logic [PW-1:0] pass_reg;
    logic [RW:0]   trial;

    if (MODE == 0) begin : g_root
        always_comb begin
            // rem_in: remaining radicand, acc_in: root so far (shifted form)
            trial    = {1'b0, rem_in} - TW'(acc_in | (QW'(1) << (2*STEP)));
            rem_next = rem_in;
            acc_next = acc_in >> 1;
            if (!trial[RW]) begin
                rem_next = trial[RW-1:0];
                acc_next = (acc_in >> 1) | (QW'(1) << (2*STEP));
            end
        end
    end else begin : g_quot
        always_comb begin
            // rem_in: partial remainder, pass_in below the flag: divisor
            trial    = {1'b0, rem_in} - (TW'(pass_in[PW-2:0]) << STEP);
            rem_next = rem_in;
            acc_next = acc_in;
            if (!trial[RW]) begin
                rem_next = trial[RW-1:0];
                acc_next = acc_in | (QW'(1) << STEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_reg[PW-1] <= 1'b0;
        end else if (en) begin
            pass_reg[PW-1] <= pass_in[PW-1];
        end
        if (en) begin
            rem_reg          <= rem_next;
            acc_reg          <= acc_next;
            pass_reg[PW-2:0] <= pass_in[PW-2:0];
        end
    end

    assign rem_out  = rem_reg;
    assign acc_out  = acc_reg;
    assign pass_out = pass_reg;
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the axis-angle rotation matrix unit. Requests carry
// an angle and an axis; a bit-exact predictor builds the expected matrix and
// zero-axis flag, and the monitor compares each result against the oldest
// prediction. Both sides idle at random, with one long output stall and one
// pause on the input side until the pipe drains.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
        logic signed [23:0] ang;
    } rot_req_t;

    typedef struct {
        logic [143:0] mat;
        logic         zflag;
    } rot_res_t;

    localparam int STEPS      = 16;
    localparam int RANDOM_REQ = 1730;
    localparam int DRAIN_CYC  = 200;
    localparam int WDOG_LIMIT = 20000;

    localparam longint FULL_TURN  = 92160;
    localparam longint QTR_TURN   = 23040;
    localparam longint EIGHTH     = 11520;
    localparam longint PI_Q_Q30   = 843314856;
    localparam longint GAIN       = 652032874;
    localparam longint UNIT_Q30   = 1073741824;
    localparam longint UNIT_Q14   = 16384;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tuser;

    rot_req_t pending_req[$];
    rot_res_t expected_mat[$];
    int       n_errors;
    bit       stim_done;
    bit       hold_in;      // sender pause until drained
    int       out_stall;    // long receiver stall, in cycles
    bit       stall_req;
    int       in_gap;
    int       out_gap;
    int       idle_cycles;

    axis_angle_rotation_matrix_unit #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // m00 m10 m20 m01 m11 m21 m02 m12 m22, low first
        .m_tuser(m_tuser)    // zero_axis
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;  // arithmetic shift on signed longint is floor
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint q30_to_q14(longint v);
        longint r;
        r = floor_shr(v + 32768, 16);
        if (r > UNIT_Q14) r = UNIT_Q14;
        if (r < -UNIT_Q14) r = -UNIT_Q14;
        return r;
    endfunction

    function automatic longint arctan_q30(int i);
        longint tbl[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[i];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_comp(longint comp, longint unsigned len);
        longint unsigned mag;
        longint q;
        mag = (comp < 0) ? -comp : comp;
        q = longint'((mag << 42) / len);
        return (comp < 0) ? -q : q;
    endfunction

    // sine/cosine of the angle in Q2.30 through the rotator
    function automatic void angle_sincos(longint ang, output longint cs,
                                         output longint sn);
        longint r, quad, x, y, z, nx;
        r = ang % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        quad = r / QTR_TURN;
        z = (r % QTR_TURN) * PI_Q_Q30 / EIGHTH;
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= arctan_q30(i);
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += arctan_q30(i);
            end
            x = nx;
        end
        case (quad)
            0: begin cs = x;  sn = y;  end
            1: begin cs = -y; sn = x;  end
            2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic rot_res_t rotation_matrix(rot_req_t q);
        rot_res_t res;
        longint c, s, cq, sq, ax, ay, az, ux, uy, uz, nc, xy, yz, zx, xs, ys, zs;
        longint m[9];
        longint unsigned len2, len;
        angle_sincos(longint'(q.ang), c, s);
        cq = q30_to_q14(c);
        sq = q30_to_q14(s);
        ax = q.ax; ay = q.ay; az = q.az;
        foreach (m[k]) m[k] = 0;
        res.zflag = 1'b0;
        if (ax == 4096 && ay == 0 && az == 0) begin
            m[0] = UNIT_Q14; m[4] = cq; m[8] = cq; m[5] = sq; m[7] = -sq;
        end else if (ax == 0 && ay == 4096 && az == 0) begin
            m[4] = UNIT_Q14; m[0] = cq; m[8] = cq; m[6] = sq; m[2] = -sq;
        end else if (ax == 0 && ay == 0 && az == 4096) begin
            m[8] = UNIT_Q14; m[0] = cq; m[4] = cq; m[1] = sq; m[3] = -sq;
        end else begin
            len2 = ax * ax + ay * ay + az * az;
            if (len2 == 0) begin
                m[0] = UNIT_Q14; m[4] = UNIT_Q14; m[8] = UNIT_Q14;
                res.zflag = 1'b1;
            end else begin
                len = int_sqrt(len2 << 24);
                ux = unit_comp(ax, len);
                uy = unit_comp(ay, len);
                uz = unit_comp(az, len);
                nc = UNIT_Q30 - c;
                xy = mul_q30(ux, uy); yz = mul_q30(uy, uz); zx = mul_q30(uz, ux);
                xs = mul_q30(ux, s);  ys = mul_q30(uy, s);  zs = mul_q30(uz, s);
                m[0] = q30_to_q14(mul_q30(mul_q30(ux, ux), nc) + c);
                m[3] = q30_to_q14(mul_q30(xy, nc) - zs);
                m[6] = q30_to_q14(mul_q30(zx, nc) + ys);
                m[1] = q30_to_q14(mul_q30(xy, nc) + zs);
                m[4] = q30_to_q14(mul_q30(mul_q30(uy, uy), nc) + c);
                m[7] = q30_to_q14(mul_q30(yz, nc) - xs);
                m[2] = q30_to_q14(mul_q30(zx, nc) - ys);
                m[5] = q30_to_q14(mul_q30(yz, nc) + xs);
                m[8] = q30_to_q14(mul_q30(mul_q30(uz, uz), nc) + c);
            end
        end
        for (int k = 0; k < 9; k++) res.mat[16*k +: 16] = m[k][15:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'(signed'($urandom_range(8)) - 4);  // tiny, near zero
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'sd0;
            3: return $urandom_range(1) ? 16'sd4096 : -16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_angle();
        case ($urandom_range(7))
            0: return 24'(signed'($urandom_range(8)) * 23040);  // quadrant edges
            1: return 24'(signed'($urandom_range(1000)) - 500);
            2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_req(logic signed [23:0] a, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
        rot_req_t q;
        q.ang = a; q.ax = x; q.ay = y; q.az = z;
        pending_req.push_back(q);
    endtask

    task automatic add_random(int n);
        logic signed [15:0] x, y, z;
        repeat (n) begin
            x = rand_comp(); y = rand_comp(); z = rand_comp();
            // a third of the axes are forced to a unit axis or to zero, to hit those paths
            case ($urandom_range(11))
                0: begin x = 16'sd4096; y = 0; z = 0; end
                1: begin x = 0; y = 16'sd4096; z = 0; end
                2: begin x = 0; y = 0; z = 16'sd4096; end
                3: begin x = 0; y = 0; z = 0; end
                default: ;
            endcase
            add_req(rand_angle(), x, y, z);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        stim_done = 1'b0;
        hold_in   = 1'b0;
        stall_req = 1'b0;
        n_errors  = 0;
        // directed: unit axes, zero axis, non-unit multiples, extreme angles
        add_req(24'sd0,        16'sd4096, 16'sd0,    16'sd0);
        add_req(24'sd23040,    16'sd0,    16'sd4096, 16'sd0);
        add_req(24'sd46080,    16'sd0,    16'sd0,    16'sd4096);
        add_req(24'sd69120,    16'sd4096, 16'sd0,    16'sd0);
        add_req(24'sd11520,    16'sd0,    16'sd0,    16'sd0);
        add_req(24'sd11520,    16'sd8192, 16'sd0,    16'sd0);
        add_req(24'sd11520,   -16'sd4096, 16'sd0,    16'sd0);
        add_req(24'sd11520,    16'sd0,   -16'sd4096, 16'sd0);
        add_req(24'sd11520,    16'sd0,    16'sd0,   -16'sd4096);
        add_req(24'sh7FFFFF,   16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_req(24'sh800000,   16'sh8000, 16'sh8000, 16'sh8000);
        add_req(-24'sd1,       16'sd1,    16'sd0,    16'sd0);
        add_req(24'sd92160,    16'sd1,    16'sd1,    16'sd1);
        add_req(-24'sd92160,   16'sd4096, 16'sd4096, 16'sd0);
        add_req(24'sd23039,    16'sh7FFF, 16'sh8000, 16'sd1);
        add_req(24'sd5000,     16'sd0,    16'sd0,    16'sd0);
        add_req(24'shFFFFFF,  -16'sd1,   -16'sd1,   -16'sd1);
        add_req(24'sh555555,   16'sh5555, 16'shAAAA, 16'sh5555);
        add_req(24'shAAAAAA,   16'shAAAA, 16'sh5555, 16'shAAAA);
        add_random(RANDOM_REQ);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // sender pause until the pipe is empty
        wait (pending_req.size() < RANDOM_REQ / 2);
        @(posedge aclk);
        hold_in <= 1'b1;
        wait (expected_mat.size() == 0);
        @(posedge aclk);
        hold_in <= 1'b0;
        // long receiver stall while the sender keeps offering
        wait (pending_req.size() < RANDOM_REQ / 4);
        @(posedge aclk);
        stall_req <= 1'b1;
        wait (pending_req.size() == 0 && !s_tvalid);
        stim_done = 1'b1;
    end

    function automatic int rand_gap();
        return ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge aclk) begin
        rot_req_t q;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            in_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            // the previous request (if any) is taken at this edge
            if (s_tvalid) expected_mat.push_back(rotation_matrix(rot_req_t'(s_tdata)));
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!hold_in && pending_req.size() > 0) begin
                q = pending_req.pop_front();
                s_tdata  <= q;
                s_tvalid <= 1'b1;
                in_gap   <= ($urandom_range(2) == 0) ? rand_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge aclk) begin
        rot_res_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            out_gap   <= 0;
            out_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_mat.size() == 0) begin
                    $display("%0t: unexpected result mat=%h zero_axis=%b",
                             $time, m_tdata, m_tuser);
                    n_errors++;
                end else begin
                    want = expected_mat.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[16*k +: 16] !== want.mat[16*k +: 16]) begin
                            $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                                     $signed(want.mat[16*k +: 16]),
                                     $signed(m_tdata[16*k +: 16]));
                            n_errors++;
                        end
                    if (m_tuser !== want.zflag) begin
                        $display("%0t: zero_axis expected %b actual %b",
                                 $time, want.zflag, m_tuser);
                        n_errors++;
                    end
                end
            end
            if (stall_req && out_stall == 0) begin
                stall_req <= 1'b0;
                out_stall <= 400;
                m_tready  <= 1'b0;
            end else if (out_stall > 1) begin
                out_stall <= out_stall - 1;
            end else if (out_gap > 0) begin
                out_gap  <= out_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (out_stall == 1) out_stall <= -1;  // stall done, never again
                if ($urandom_range(3) == 0) out_gap <= rand_gap();
            end
        end
    end

    // ---------------------------------------------------------------- watchdog / end
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        wait (stim_done && expected_mat.size() == 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (n_errors == 0 && !m_tvalid) begin
            $display("Regression PASS");
        end else begin
            if (m_tvalid) $display("%0t: extra result pending at end", $time);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WDOG_LIMIT);
        $display("%0t: timeout, %0d results outstanding", $time, expected_mat.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/aarm_sqrt_cell.sv
rtl/core/axis_angle_rotation_matrix_unit.sv
dv/tb.sv
